### design/mlc_pkg.sv
// Shared types, constants and format decode for the mip level layout calculator.
// Used by mlc_mul, mlc_seq, mip_level_layout_calc and mlc_chk. No dependencies.
`timescale 1ns / 1ps

package mlc_pkg;

    localparam int MAX_DIM_DEF      = 16384;
    localparam int FORMAT_COUNT_DEF = 79;
    localparam int KNOWN_FORMATS    = 79;

    // Ceiling division by the block size uses an exact reciprocal multiply.
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int DIM_W       = 15;
    localparam int X_W         = DIM_W + 1;
    localparam int PITCH_W     = 20;
    localparam int MUL_A_W     = RECIP_W;
    localparam int MUL_B_W     = PITCH_W;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int SIZE_W      = PITCH_W + DIM_W;
    localparam int OFS_W       = 33;
    localparam int BLK_W       = 4;
    localparam int BYTES_W     = 5;

    typedef struct packed {
        logic [6:0]       format_index;
        logic [DIM_W-1:0] base_width;
        logic [DIM_W-1:0] base_height;
        logic [3:0]       mip_index;
    } req_t;

    typedef struct packed {
        logic [OFS_W-1:0] level_offset;
        logic [18:0]      row_pitch;
        logic [DIM_W-1:0] row_count;
        logic [OFS_W-1:0] level_size;
        logic             bad_format;
    } rsp_t;

    typedef struct packed {
        logic [BYTES_W-1:0] bytes;
        logic [BLK_W-1:0]   bw;
        logic [BLK_W-1:0]   bh;
    } fmt_info_t;

    typedef struct packed {
        logic busy;
        logic done;
    } seq_ctrl_t;

    function automatic logic [BYTES_W-1:0] fmt_bytes(input logic [6:0] fmt);
        logic [BYTES_W-1:0] b;
        b = '0;
        unique case (fmt) inside
            [7'd1:7'd3]:                   b = 5'd16;
            [7'd4:7'd6], [7'd10:7'd12]:    b = 5'd8;
            [7'd7:7'd9]:                   b = 5'd12;
            [7'd13:7'd18], [7'd22:7'd25]:  b = 5'd4;
            [7'd19:7'd21], 7'd26, 7'd30:   b = 5'd2;
            7'd27:                         b = 5'd1;
            7'd28, 7'd29:                  b = 5'd4;
            7'd31, 7'd32, 7'd37, 7'd38:    b = 5'd8;
            [7'd33:7'd36], [7'd39:7'd72]:  b = 5'd16;
            [7'd73:7'd75], 7'd77, 7'd78:   b = 5'd4;
            7'd76:                         b = 5'd8;
            default:                       b = 5'd0;
        endcase
        return b;
    endfunction

    function automatic fmt_info_t fmt_decode(input logic [6:0] fmt);
        fmt_info_t f;
        f.bytes = fmt_bytes(fmt);
        f.bw    = 4'd1;
        f.bh    = 4'd1;
        unique case (fmt) inside
            [7'd31:7'd46]: begin f.bw = 4'd4;  f.bh = 4'd4;  end
            7'd47, 7'd48:  begin f.bw = 4'd5;  f.bh = 4'd4;  end
            7'd49, 7'd50:  begin f.bw = 4'd5;  f.bh = 4'd5;  end
            7'd51, 7'd52:  begin f.bw = 4'd6;  f.bh = 4'd5;  end
            7'd53, 7'd54:  begin f.bw = 4'd6;  f.bh = 4'd6;  end
            7'd55, 7'd56:  begin f.bw = 4'd8;  f.bh = 4'd5;  end
            7'd57, 7'd58:  begin f.bw = 4'd8;  f.bh = 4'd6;  end
            7'd59, 7'd60:  begin f.bw = 4'd8;  f.bh = 4'd8;  end
            7'd61, 7'd62:  begin f.bw = 4'd10; f.bh = 4'd5;  end
            7'd63, 7'd64:  begin f.bw = 4'd10; f.bh = 4'd6;  end
            7'd65, 7'd66:  begin f.bw = 4'd10; f.bh = 4'd8;  end
            7'd67, 7'd68:  begin f.bw = 4'd10; f.bh = 4'd10; end
            7'd69, 7'd70:  begin f.bw = 4'd12; f.bh = 4'd10; end
            7'd71, 7'd72:  begin f.bw = 4'd12; f.bh = 4'd12; end
            default:       begin f.bw = 4'd1;  f.bh = 4'd1;  end
        endcase
        return f;
    endfunction

    // ceil(2^RECIP_SHIFT / d); exact floor quotient for any 16-bit dividend
    function automatic logic [RECIP_W-1:0] blk_recip(input logic [BLK_W-1:0] d);
        logic [RECIP_W-1:0] r;
        unique case (d)
            4'd4:    r = 21'd262144;
            4'd5:    r = 21'd209716;
            4'd6:    r = 21'd174763;
            4'd8:    r = 21'd131072;
            4'd10:   r = 21'd104858;
            4'd12:   r = 21'd87382;
            default: r = 21'd1048576;
        endcase
        return r;
    endfunction

endpackage

### design/mlc_mul.sv
// Shared multiplier with a registered product.
// Depends on mlc_pkg for operand widths.
`timescale 1ns / 1ps

module mlc_mul (
    input  logic                        clk,
    input  logic                        en,
    input  logic [mlc_pkg::MUL_A_W-1:0] a,
    input  logic [mlc_pkg::MUL_B_W-1:0] b,
    output logic [mlc_pkg::PROD_W-1:0]  prod
);
    import mlc_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(a) * PROD_W'(b);
        end
    end

    assign prod = prod_reg;

endmodule

### design/mlc_seq.sv
// Sequencer that walks the mip chain, one level per five-step pass over the
// shared multiplier. Depends on mlc_pkg and drives an mlc_mul instance.
`timescale 1ns / 1ps

module mlc_seq #(
    parameter int MAX_DIM      = mlc_pkg::MAX_DIM_DEF,
    parameter int FORMAT_COUNT = mlc_pkg::FORMAT_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  mlc_pkg::req_t               item,
    input  logic                        out_free,
    input  logic [mlc_pkg::PROD_W-1:0]  prod,
    output logic                        mul_en,
    output logic [mlc_pkg::MUL_A_W-1:0] mul_a,
    output logic [mlc_pkg::MUL_B_W-1:0] mul_b,
    output mlc_pkg::rsp_t               result,
    output mlc_pkg::seq_ctrl_t          ctrl
);
    import mlc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_W    = 7'b0000010,
        S_H    = 7'b0000100,
        S_P    = 7'b0001000,
        S_S    = 7'b0010000,
        S_A    = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [DIM_W-1:0]   w_reg, h_reg;
    logic [BLK_W-1:0]   bw_reg, bh_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [3:0]         mip_reg, lvl_reg;
    logic [DIM_W-1:0]   ew_reg, eh_reg;
    logic [PITCH_W-1:0] pitch_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [OFS_W-1:0]   offset_reg;
    logic               bad_reg;

    fmt_info_t        fi;
    logic             fmt_bad;
    logic [DIM_W-1:0] w_in, h_in;
    logic [DIM_W-1:0] w_half, h_half;
    logic [X_W-1:0]   xw, xh;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if ({2'b00, v} > 17'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

    assign fi      = fmt_decode(item.format_index);
    assign fmt_bad = ({1'b0, item.format_index} >= 8'(FORMAT_COUNT))
                  || ({1'b0, item.format_index} >= 8'(KNOWN_FORMATS));
    assign w_in    = clamp_dim(item.base_width);
    assign h_in    = clamp_dim(item.base_height);

    // halve with a floor of one
    assign w_half = (w_reg[DIM_W-1:1] == '0) ? DIM_W'(1) : {1'b0, w_reg[DIM_W-1:1]};
    assign h_half = (h_reg[DIM_W-1:1] == '0) ? DIM_W'(1) : {1'b0, h_reg[DIM_W-1:1]};

    assign xw = X_W'(w_reg) + X_W'(bw_reg) - X_W'(1);
    assign xh = X_W'(h_reg) + X_W'(bh_reg) - X_W'(1);

    always_comb
    begin
        state_next = state_reg;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = fmt_bad ? S_DONE : S_W;
                end
            end
            S_W:
            begin
                mul_en     = 1'b1;
                mul_a      = blk_recip(bw_reg);
                mul_b      = MUL_B_W'(xw);
                state_next = S_H;
            end
            S_H:
            begin
                mul_en     = 1'b1;
                mul_a      = blk_recip(bh_reg);
                mul_b      = MUL_B_W'(xh);
                state_next = S_P;
            end
            S_P:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(bytes_reg);
                mul_b      = MUL_B_W'(ew_reg);
                state_next = S_S;
            end
            S_S:
            begin
                // pitch is still in the product register
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(eh_reg);
                mul_b      = prod[PITCH_W-1:0];
                state_next = S_A;
            end
            S_A:
            begin
                state_next = (lvl_reg == mip_reg) ? S_DONE : S_W;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    w_reg      <= w_in;
                    h_reg      <= h_in;
                    bw_reg     <= fi.bw;
                    bh_reg     <= fi.bh;
                    bytes_reg  <= fi.bytes;
                    mip_reg    <= item.mip_index;
                    lvl_reg    <= '0;
                    offset_reg <= '0;
                    bad_reg    <= fmt_bad;
                    ew_reg     <= '0;
                    eh_reg     <= '0;
                    pitch_reg  <= '0;
                    size_reg   <= '0;
                end
            end
            S_H:
            begin
                ew_reg <= prod[RECIP_SHIFT +: DIM_W];
            end
            S_P:
            begin
                eh_reg <= prod[RECIP_SHIFT +: DIM_W];
            end
            S_S:
            begin
                pitch_reg <= prod[PITCH_W-1:0];
            end
            S_A:
            begin
                size_reg <= prod[SIZE_W-1:0];
                if (lvl_reg != mip_reg)
                begin
                    offset_reg <= offset_reg + prod[OFS_W-1:0];
                    w_reg      <= w_half;
                    h_reg      <= h_half;
                    lvl_reg    <= lvl_reg + 4'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result.level_offset = offset_reg;
    assign result.row_pitch    = pitch_reg[18:0];
    assign result.row_count    = eh_reg;
    assign result.level_size   = size_reg[OFS_W-1:0];
    assign result.bad_format   = bad_reg;

    assign ctrl.busy = (state_reg != S_IDLE);
    assign ctrl.done = (state_reg == S_DONE);

endmodule

### design/mip_level_layout_calc.sv
// Mip level layout calculator: one request in, one layout beat out.
// A request walks the mip chain up to mip_index through the single shared multiplier,
// used four times per mip level; a bad format skips the walk. No new request is taken
// until the result has left the sequencer. The sequencer holds the finished result
// while the output beat is stalled.
// Reset (rst_n, async, active low) clears the sequencer and the output valid.
`timescale 1ns / 1ps

module mip_level_layout_calc #(
    parameter int MAX_DIM      = mlc_pkg::MAX_DIM_DEF,
    parameter int FORMAT_COUNT = mlc_pkg::FORMAT_COUNT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  mlc_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output mlc_pkg::rsp_t rsp_data
);
    import mlc_pkg::*;

    logic               start;
    logic               out_free;
    logic               mul_en;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    rsp_t               result;
    seq_ctrl_t          ctrl;

    logic rsp_valid_reg;
    rsp_t rsp_data_reg;

    assign req_stall = ctrl.busy;
    assign start     = req_valid && !ctrl.busy;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    mlc_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    mlc_seq #(
        .MAX_DIM      (MAX_DIM),
        .FORMAT_COUNT (FORMAT_COUNT)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (req_data),
        .out_free (out_free),
        .prod     (prod),
        .mul_en   (mul_en),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .result   (result),
        .ctrl     (ctrl)
    );

    // Output register: load when finished and the slot is free, drop once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctrl.done && out_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.done && out_free)
        begin
            rsp_data_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

### design/mlc_chk.sv
// Port-level checks for mip_level_layout_calc, attached by bind.
// Depends on mlc_pkg for the beat types.
`timescale 1ns / 1ps

module mlc_chk (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input mlc_pkg::req_t req_data,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input mlc_pkg::rsp_t rsp_data
);
    import mlc_pkg::*;

    // a stalled result beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("result beat changed while stalled");

    // the block is busy right after taking a request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken without going busy");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.bad_format |->
            rsp_data.level_offset == '0 && rsp_data.row_pitch == '0 &&
            rsp_data.row_count == '0 && rsp_data.level_size == '0)
        else $error("bad format beat carries nonzero layout");

    a_rows_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.bad_format |-> rsp_data.row_count != '0)
        else $error("good format beat with zero rows");

endmodule

bind mip_level_layout_calc mlc_chk u_mlc_chk (.*);

### tb/mip_level_layout_calc_test.sv
// Self-checking testbench for mip_level_layout_calc: a local predictor of the
// mip-chain layout compared against every response beat. Depends on mlc_pkg.
`timescale 1ns / 1ps

module mip_level_layout_calc_test;
    import mlc_pkg::*;

    localparam int IDLE_PCT     = 31;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 120;

    // Format number landmarks
    localparam int FMT_NONE       = 0;
    localparam int FMT_WIDE16     = 1;
    localparam int FMT_RGBA8      = 13;
    localparam int FMT_BYTE1      = 27;
    localparam int FMT_HALF2      = 30;
    localparam int FMT_BC_FIRST   = 31;
    localparam int FMT_BC_LAST    = 44;
    localparam int FMT_ASTC_FIRST = 45;
    localparam int FMT_ASTC_LAST  = 72;
    localparam int FMT_TAIL_FIRST = 73;
    localparam int FMT_PACKED8    = 76;
    localparam int FMT_TAIL_LAST  = 78;
    localparam int FMT_CODE_MAX   = 127;

    // Bytes per element, or per block for compressed formats
    int unsigned elem_size [0:78] = '{
        0,
        16, 16, 16, 8, 8, 8, 12, 12, 12, 8, 8, 8,
        4, 4, 4, 4, 4, 4, 2, 2, 2,
        4, 4, 4, 4, 2, 1, 4, 4, 2,
        8, 8, 16, 16, 16, 16, 8, 8, 16, 16, 16, 16, 16, 16,
        16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16,
        16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16, 16,
        4, 4, 4, 8, 4, 4
    };
    // ASTC footprints, one per pair of formats
    int unsigned astc_blk_w [0:13] = '{4, 5, 5, 6, 6, 8, 8, 8, 10, 10, 10, 10, 12, 12};
    int unsigned astc_blk_h [0:13] = '{4, 4, 5, 5, 6, 5, 6, 8, 5, 6, 8, 10, 10, 12};

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data  = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;

    rsp_t pending_layouts [$];
    rsp_t want;
    bit   quiet = 1'b0;
    int   n_fail = 0;
    int   n_req = 0;
    int   n_rsp = 0;
    int   n_bad_fmt = 0;
    int   idle_cycles = 0;

    mip_level_layout_calc dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Walk the mip chain up to the requested level
    function automatic rsp_t level_layout(input req_t r);
        rsp_t o;
        longint unsigned w, h, bw, bh, nbytes, ofs, pitch, rows, sz;
        int unsigned lvl;
        o = '0;
        if (r.format_index >= FORMAT_COUNT_DEF || r.format_index >= KNOWN_FORMATS)
        begin
            o.bad_format = 1'b1;
            return o;
        end
        w = r.base_width;
        h = r.base_height;
        if (w == 0) w = 1;
        if (h == 0) h = 1;
        if (w > MAX_DIM_DEF) w = MAX_DIM_DEF;
        if (h > MAX_DIM_DEF) h = MAX_DIM_DEF;
        nbytes = elem_size[r.format_index];
        bw = 1;
        bh = 1;
        if (r.format_index >= FMT_ASTC_FIRST && r.format_index <= FMT_ASTC_LAST)
        begin
            bw = astc_blk_w[((r.format_index - FMT_ASTC_FIRST) >> 1) % 14];
            bh = astc_blk_h[((r.format_index - FMT_ASTC_FIRST) >> 1) % 14];
        end
        else if (r.format_index >= FMT_BC_FIRST && r.format_index <= FMT_BC_LAST)
        begin
            bw = 4;
            bh = 4;
        end
        ofs = 0;
        pitch = 0;
        rows = 0;
        sz = 0;
        for (lvl = 0; lvl <= r.mip_index; lvl++)
        begin
            pitch = ((w + bw - 1) / bw) * nbytes;
            rows  = (h + bh - 1) / bh;
            sz    = pitch * rows;
            if (lvl < r.mip_index) ofs += sz;
            w = w >> 1;
            h = h >> 1;
            if (w == 0) w = 1;
            if (h == 0) h = 1;
        end
        o.level_offset = ofs[32:0];
        o.row_pitch    = pitch[18:0];
        o.row_count    = rows[14:0];
        o.level_size   = sz[32:0];
        return o;
    endfunction

    function automatic logic [14:0] rand_dim();
        case ($urandom_range(9))
            0:       return 15'($urandom_range(32767));
            1, 2:    return 15'($urandom_range(1, 16));
            3:       return 15'(1 << $urandom_range(14));
            default: return 15'($urandom_range(1, 16384));
        endcase
    endfunction

    function automatic logic [3:0] rand_mip();
        if ($urandom_range(1)) return 4'($urandom_range(4));
        return 4'($urandom_range(15));
    endfunction

    // Offer one request beat and hold it until taken
    task automatic send_req(input int fmt, input int w, input int h, input int mip);
        req_t r;
        r.format_index = 7'(fmt);
        r.base_width   = 15'(w);
        r.base_height  = 15'(h);
        r.mip_index    = 4'(mip);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do @(posedge clk); while (req_stall);
        pending_layouts.push_back(level_layout(r));
        n_req++;
        if (r.format_index >= FORMAT_COUNT_DEF) n_bad_fmt++;
    endtask

    // Drop valid and hold until every outstanding beat has returned
    task automatic wait_drained();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending_layouts.size() != 0);
    endtask

    task automatic test_directed();
        send_req(FMT_NONE,            16384, 16384, 0);
        send_req(FMT_WIDE16,          16384, 16384, 0);
        send_req(FMT_WIDE16,          16384, 16384, 15);
        send_req(FMT_BYTE1,           1,     1,     0);
        send_req(FMT_BYTE1,           0,     0,     15);
        send_req(FMT_RGBA8,           32767, 32767, 3);
        send_req(FMT_RGBA8,           16385, 1,     1);
        send_req(FMT_HALF2,           16384, 1,     15);
        send_req(FMT_BC_FIRST,        1,     1,     0);
        send_req(FMT_BC_LAST,         16384, 16384, 15);
        send_req(FMT_ASTC_FIRST,      13,    7,     2);
        send_req(FMT_ASTC_FIRST + 5,  1000,  999,   4);
        send_req(FMT_ASTC_FIRST + 8,  777,   555,   3);
        send_req(FMT_ASTC_FIRST + 14, 4097,  33,    6);
        send_req(FMT_ASTC_FIRST + 16, 1,     16384, 15);
        send_req(FMT_ASTC_FIRST + 23, 321,   123,   1);
        send_req(FMT_ASTC_FIRST + 26, 16384, 16384, 0);
        send_req(FMT_ASTC_LAST,       16383, 1,     14);
        send_req(FMT_TAIL_FIRST,      300,   17,    5);
        send_req(FMT_PACKED8,         2048,  1024,  11);
        send_req(FMT_TAIL_LAST,       5,     3,     2);
        send_req(FORMAT_COUNT_DEF,    100,   100,   15);
        send_req(FMT_CODE_MAX,        32767, 32767, 15);
    endtask

    task automatic test_format_sweep();
        int f;
        for (f = 0; f <= FMT_CODE_MAX; f++)
            send_req(f, rand_dim(), rand_dim(), rand_mip());
    endtask

    task automatic test_drain_pause();
        int i;
        for (i = 0; i < 20; i++)
            send_req($urandom_range(FMT_TAIL_LAST), rand_dim(), rand_dim(), rand_mip());
        wait_drained();
        for (i = 0; i < 20; i++)
            send_req($urandom_range(FMT_TAIL_LAST), rand_dim(), rand_dim(), rand_mip());
    endtask

    task automatic test_random_mix(input int count);
        int i;
        int fmt;
        for (i = 0; i < count; i++)
        begin
            // Run the first stretch with neither side idling
            quiet = (i < 150);
            if ($urandom_range(9) == 0)
                fmt = $urandom_range(FMT_CODE_MAX, FORMAT_COUNT_DEF);
            else
                fmt = $urandom_range(FMT_TAIL_LAST);
            send_req(fmt, rand_dim(), rand_dim(), rand_mip());
        end
        quiet = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            n_rsp++;
            if (pending_layouts.size() == 0)
            begin
                $error("unexpected layout beat: %p", rsp_data);
                n_fail++;
            end
            else
            begin
                want = pending_layouts.pop_front();
                if (rsp_data.level_offset !== want.level_offset)
                begin
                    $error("level_offset: expected %0d, got %0d",
                           want.level_offset, rsp_data.level_offset);
                    n_fail++;
                end
                if (rsp_data.row_pitch !== want.row_pitch)
                begin
                    $error("row_pitch: expected %0d, got %0d",
                           want.row_pitch, rsp_data.row_pitch);
                    n_fail++;
                end
                if (rsp_data.row_count !== want.row_count)
                begin
                    $error("row_count: expected %0d, got %0d",
                           want.row_count, rsp_data.row_count);
                    n_fail++;
                end
                if (rsp_data.level_size !== want.level_size)
                begin
                    $error("level_size: expected %0d, got %0d",
                           want.level_size, rsp_data.level_size);
                    n_fail++;
                end
                if (rsp_data.bad_format !== want.bad_format)
                begin
                    $error("bad_format: expected %0d, got %0d",
                           want.bad_format, rsp_data.bad_format);
                    n_fail++;
                end
            end
        end
    end

    // Abort when no beat moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles, %0d outstanding",
                     idle_cycles, pending_layouts.size());
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_format_sweep();
        test_drain_pause();
        test_random_mix(750);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d requests (%0d bad format codes), %0d layout beats checked",
                 n_req, n_bad_fmt, n_rsp);
        $display("all 128 format codes, mip 0..15, clamped and block-rounded sizes");
        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sim.f
design/mlc_pkg.sv
design/mlc_mul.sv
design/mlc_seq.sv
design/mip_level_layout_calc.sv
design/mlc_chk.sv
tb/mip_level_layout_calc_test.sv
